@@ rtl/assert_macros.svh @@
// Assertion macros used by the translator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define RIT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define RIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rit_pkg.sv @@
// Package: widths, codes and types of the resource ID translator
`default_nettype none
package rit_pkg;
  localparam int ID_W      = 32;
  localparam int VIS_DEPTH = 32;
  localparam int COL_DEPTH = 256;
  localparam int VIS_AW    = (VIS_DEPTH > 1) ? $clog2(VIS_DEPTH) : 1;
  localparam int COL_AW    = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
  localparam int VIS_CW    = $clog2(VIS_DEPTH + 1);
  localparam int COL_CW    = $clog2(COL_DEPTH + 1);
  localparam int IDX_W     = (COL_CW > VIS_CW) ? COL_CW : VIS_CW;
  localparam int BIT_AW    = $clog2(ID_W);
  localparam int BIT_PW    = BIT_AW + 1;
  localparam int SLOT_CNT  = 6;
  localparam int SPEC_CNT  = 3;

  localparam logic [2:0] ACT_XLATE   = 3'd0;
  localparam logic [2:0] ACT_CLEAR   = 3'd1;
  localparam logic [2:0] ACT_SPECIAL = 3'd2;
  localparam logic [2:0] ACT_SVIS    = 3'd3;
  localparam logic [2:0] ACT_TVIS    = 3'd4;
  localparam logic [2:0] ACT_SCOL    = 3'd5;
  localparam logic [2:0] ACT_TCOL    = 3'd6;

  localparam logic [2:0] KIND_BASE  = 3'd0;
  localparam logic [2:0] KIND_ROOT  = 3'd1;
  localparam logic [2:0] KIND_COLOR = 3'd4;
  localparam logic [2:0] KIND_VIS   = 3'd5;
  localparam logic [2:0] KIND_NONE  = 3'd6;
  localparam logic [2:0] KIND_LOAD  = 3'd7;

  localparam logic [2:0] REG_SRC_BASE = 3'd0;
  localparam logic [2:0] REG_SRC_MASK = 3'd1;
  localparam logic [2:0] REG_TGT_BASE = 3'd2;
  localparam logic [2:0] REG_TGT_MASK = 3'd3;
  localparam logic [2:0] REG_EXACT    = 3'd4;
  localparam logic [2:0] REG_COLOR_EN = 3'd5;

  typedef struct packed {
    logic            start;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] src_mask;
    logic [ID_W-1:0] tgt_mask;
    logic [ID_W-1:0] tgt_base;
  } remap_req_t;

  typedef struct packed {
    logic            done;
    logic [ID_W-1:0] result;
  } remap_rsp_t;
endpackage
`default_nettype wire

@@ rtl/rit_if.sv @@
// Channel interfaces: input items, result items, configuration writes
`default_nettype none
interface rit_in_if;
  logic                    valid;
  logic                    ready;
  logic [2:0]              action;
  logic [2:0]              slot;
  logic [rit_pkg::ID_W-1:0] value;
  modport source (output valid, action, slot, value, input ready);
  modport sink (input valid, action, slot, value, output ready);
endinterface

interface rit_out_if;
  logic                    valid;
  logic                    ready;
  logic [rit_pkg::ID_W-1:0] result_id;
  logic [2:0]              match_kind;
  logic                    table_full;
  modport source (output valid, result_id, match_kind, table_full, input ready);
  modport sink (input valid, result_id, match_kind, table_full, output ready);
endinterface

interface rit_cfg_if;
  logic                    valid;
  logic                    ready;
  logic [2:0]              index;
  logic [rit_pkg::ID_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/resource_id_translator_core.sv @@
// Resource ID translator top level: sequencer, registers and list memories
// Path from the accepting edge to out valid: loads, base and special answers are posted from S_EVAL;
// exact remap waits for the remap unit. A colour search reads up to min(source, target colour count)
// entries, a visual search up to the source visual count, and a visual hit adds a target read.
// One item at a time; ready returns with out valid.
// Reset clears registers, counts and special slots; list memories are undefined until written.
`default_nettype none
`include "assert_macros.svh"
module resource_id_translator_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rit_in_if.sink     in_ch,
  rit_out_if.source  out_ch,
  rit_cfg_if.sink    cfg_ch
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_REMAP = 3'd2;
  localparam logic [2:0] S_COL   = 3'd3;
  localparam logic [2:0] S_VIS   = 3'd4;
  localparam logic [2:0] S_VDAT  = 3'd5;

  localparam int IW = rit_pkg::IDX_W;

  logic [2:0]               state_r, state_nxt;
  logic [2:0]               act_r, slot_r;
  logic [rit_pkg::ID_W-1:0] id_r;
  logic [rit_pkg::ID_W-1:0] src_base_r, src_mask_r, tgt_base_r, tgt_mask_r;
  logic                     exact_r, color_en_r;
  logic [rit_pkg::ID_W-1:0] spec_ids_r [rit_pkg::SLOT_CNT];
  logic [rit_pkg::SLOT_CNT-1:0] spec_vld_r;
  logic [rit_pkg::VIS_CW-1:0] src_vc_r, tgt_vc_r;
  logic [rit_pkg::COL_CW-1:0] src_cc_r, tgt_cc_r;
  logic [IW-1:0]            idx_r, idx_nxt;
  logic                     chk_r, chk_nxt;

  logic                     out_valid_r;
  logic [rit_pkg::ID_W-1:0] out_id_r;
  logic [2:0]               out_kind_r;
  logic                     out_full_r;
  logic                     post;
  logic [rit_pkg::ID_W-1:0] post_id;
  logic [2:0]               post_kind;
  logic                     post_full;
  logic                     out_free;

  logic                     base_hit, spec_any;
  logic [1:0]               spec_sel;
  logic [rit_pkg::COL_CW-1:0] col_lim;
  logic [IW-1:0]            mi;
  logic [rit_pkg::VIS_AW-1:0] tvis_addr;

  logic                     we_svis, we_tvis, we_scol, we_tcol;
  logic                     re_col, re_svis, re_tvis;
  logic                     do_clear, do_special;
  logic [rit_pkg::ID_W-1:0] svis_q, tvis_q, scol_q, tcol_q;

  rit_pkg::remap_req_t remap_req;
  rit_pkg::remap_rsp_t remap_rsp;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign base_hit = (id_r & ~src_mask_r) == src_base_r;
  assign col_lim  = (src_cc_r < tgt_cc_r) ? src_cc_r : tgt_cc_r;
  assign mi       = idx_r - 1'b1;
  assign tvis_addr = (mi < IW'(tgt_vc_r)) ? mi[rit_pkg::VIS_AW-1:0] : '0;

  always_comb begin
    spec_any = 1'b0;
    spec_sel = '0;
    for (int i = rit_pkg::SPEC_CNT - 1; i >= 0; i--) begin
      if (spec_vld_r[i] && id_r == spec_ids_r[i]) begin
        spec_any = 1'b1;
        spec_sel = 2'(i);
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    chk_nxt    = chk_r;
    post       = 1'b0;
    post_id    = '0;
    post_kind  = rit_pkg::KIND_LOAD;
    post_full  = 1'b0;
    we_svis    = 1'b0;
    we_tvis    = 1'b0;
    we_scol    = 1'b0;
    we_tcol    = 1'b0;
    re_col     = 1'b0;
    re_svis    = 1'b0;
    re_tvis    = 1'b0;
    do_clear   = 1'b0;
    do_special = 1'b0;
    remap_req.start    = 1'b0;
    remap_req.id       = id_r;
    remap_req.src_mask = src_mask_r;
    remap_req.tgt_mask = tgt_mask_r;
    remap_req.tgt_base = tgt_base_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (act_r == rit_pkg::ACT_XLATE) begin
          idx_nxt = '0;
          chk_nxt = 1'b0;
          if (base_hit && exact_r) begin
            remap_req.start = 1'b1;
            state_nxt = S_REMAP;
          end else if (base_hit) begin
            if (out_free) begin
              post      = 1'b1;
              post_id   = (id_r & src_mask_r) | tgt_base_r;
              post_kind = rit_pkg::KIND_BASE;
              state_nxt = S_IDLE;
            end
          end else if (spec_any) begin
            if (out_free) begin
              post      = 1'b1;
              post_id   = spec_ids_r[{1'b0, spec_sel} + 3'd3];
              post_kind = rit_pkg::KIND_ROOT + {1'b0, spec_sel};
              state_nxt = S_IDLE;
            end
          end else if (color_en_r) begin
            state_nxt = S_COL;
          end else begin
            state_nxt = S_VIS;
          end
        end else if (out_free) begin
          post      = 1'b1;
          state_nxt = S_IDLE;
          case (act_r)
            rit_pkg::ACT_CLEAR:   do_clear = 1'b1;
            rit_pkg::ACT_SPECIAL: do_special = 1'b1;
            rit_pkg::ACT_SVIS: begin
              post_full = (src_vc_r >= rit_pkg::VIS_CW'(rit_pkg::VIS_DEPTH));
              we_svis   = !post_full;
            end
            rit_pkg::ACT_TVIS: begin
              post_full = (tgt_vc_r >= rit_pkg::VIS_CW'(rit_pkg::VIS_DEPTH));
              we_tvis   = !post_full;
            end
            rit_pkg::ACT_SCOL: begin
              post_full = (src_cc_r >= rit_pkg::COL_CW'(rit_pkg::COL_DEPTH));
              we_scol   = !post_full;
            end
            rit_pkg::ACT_TCOL: begin
              post_full = (tgt_cc_r >= rit_pkg::COL_CW'(rit_pkg::COL_DEPTH));
              we_tcol   = !post_full;
            end
            default: ;
          endcase
        end
      end
      S_REMAP: begin
        if (remap_rsp.done && out_free) begin
          post      = 1'b1;
          post_id   = remap_rsp.result;
          post_kind = rit_pkg::KIND_BASE;
          state_nxt = S_IDLE;
        end
      end
      S_COL: begin
        if (chk_r && scol_q == id_r) begin
          if (out_free) begin
            post      = 1'b1;
            post_id   = tcol_q;
            post_kind = rit_pkg::KIND_COLOR;
            state_nxt = S_IDLE;
          end
        end else if (idx_r < IW'(col_lim)) begin
          re_col  = 1'b1;
          idx_nxt = idx_r + 1'b1;
          chk_nxt = 1'b1;
        end else begin
          idx_nxt   = '0;
          chk_nxt   = 1'b0;
          state_nxt = S_VIS;
        end
      end
      S_VIS: begin
        if (chk_r && svis_q == id_r) begin
          re_tvis   = 1'b1;
          state_nxt = S_VDAT;
        end else if (idx_r < IW'(src_vc_r)) begin
          re_svis = 1'b1;
          idx_nxt = idx_r + 1'b1;
          chk_nxt = 1'b1;
        end else if (out_free) begin
          post      = 1'b1;
          post_id   = id_r;
          post_kind = rit_pkg::KIND_NONE;
          state_nxt = S_IDLE;
        end
      end
      S_VDAT: begin
        if (out_free) begin
          post      = 1'b1;
          post_id   = tvis_q;
          post_kind = rit_pkg::KIND_VIS;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      src_base_r  <= '0;
      src_mask_r  <= '0;
      tgt_base_r  <= '0;
      tgt_mask_r  <= '0;
      exact_r     <= 1'b0;
      color_en_r  <= 1'b0;
      spec_vld_r  <= '0;
      src_vc_r    <= '0;
      tgt_vc_r    <= '0;
      src_cc_r    <= '0;
      tgt_cc_r    <= '0;
      chk_r       <= 1'b0;
      for (int i = 0; i < rit_pkg::SLOT_CNT; i++) spec_ids_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      chk_r   <= chk_nxt;
      if (post) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          rit_pkg::REG_SRC_BASE: src_base_r <= cfg_ch.data;
          rit_pkg::REG_SRC_MASK: src_mask_r <= cfg_ch.data;
          rit_pkg::REG_TGT_BASE: tgt_base_r <= cfg_ch.data;
          rit_pkg::REG_TGT_MASK: tgt_mask_r <= cfg_ch.data;
          rit_pkg::REG_EXACT:    exact_r    <= cfg_ch.data[0];
          rit_pkg::REG_COLOR_EN: color_en_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (do_clear) begin
        spec_vld_r <= '0;
        src_vc_r   <= '0;
        tgt_vc_r   <= '0;
        src_cc_r   <= '0;
        tgt_cc_r   <= '0;
        for (int i = 0; i < rit_pkg::SLOT_CNT; i++) spec_ids_r[i] <= '0;
      end
      if (do_special) begin
        for (int i = 0; i < rit_pkg::SLOT_CNT; i++) begin
          if (slot_r == 3'(i)) begin
            spec_ids_r[i] <= id_r;
            spec_vld_r[i] <= 1'b1;
          end
        end
      end
      if (we_svis) src_vc_r <= src_vc_r + 1'b1;
      if (we_tvis) tgt_vc_r <= tgt_vc_r + 1'b1;
      if (we_scol) src_cc_r <= src_cc_r + 1'b1;
      if (we_tcol) tgt_cc_r <= tgt_cc_r + 1'b1;
    end
    idx_r <= idx_nxt;
    if (in_ch.valid && in_ch.ready) begin
      act_r  <= in_ch.action;
      slot_r <= in_ch.slot;
      id_r   <= in_ch.value;
    end
    if (post) begin
      out_id_r   <= post_id;
      out_kind_r <= post_kind;
      out_full_r <= post_full;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.result_id  = out_id_r;
  assign out_ch.match_kind = out_kind_r;
  assign out_ch.table_full = out_full_r;

  rit_remap u_remap (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (remap_req),
    .rsp   (remap_rsp)
  );

  rit_ram #(.DEPTH(rit_pkg::VIS_DEPTH), .WIDTH(rit_pkg::ID_W)) u_svis (
    .clk   (clk),
    .we    (we_svis),
    .waddr (src_vc_r[rit_pkg::VIS_AW-1:0]),
    .wdata (id_r),
    .re    (re_svis),
    .raddr (idx_r[rit_pkg::VIS_AW-1:0]),
    .rdata (svis_q)
  );

  rit_ram #(.DEPTH(rit_pkg::VIS_DEPTH), .WIDTH(rit_pkg::ID_W)) u_tvis (
    .clk   (clk),
    .we    (we_tvis),
    .waddr (tgt_vc_r[rit_pkg::VIS_AW-1:0]),
    .wdata (id_r),
    .re    (re_tvis),
    .raddr (tvis_addr),
    .rdata (tvis_q)
  );

  rit_ram #(.DEPTH(rit_pkg::COL_DEPTH), .WIDTH(rit_pkg::ID_W)) u_scol (
    .clk   (clk),
    .we    (we_scol),
    .waddr (src_cc_r[rit_pkg::COL_AW-1:0]),
    .wdata (id_r),
    .re    (re_col),
    .raddr (idx_r[rit_pkg::COL_AW-1:0]),
    .rdata (scol_q)
  );

  rit_ram #(.DEPTH(rit_pkg::COL_DEPTH), .WIDTH(rit_pkg::ID_W)) u_tcol (
    .clk   (clk),
    .we    (we_tcol),
    .waddr (tgt_cc_r[rit_pkg::COL_AW-1:0]),
    .wdata (id_r),
    .re    (re_col),
    .raddr (idx_r[rit_pkg::COL_AW-1:0]),
    .rdata (tcol_q)
  );

  `RIT_ASSERT_NEXT(a_accept_eval, in_ch.valid && in_ch.ready, state_r == S_EVAL, "accepted item not evaluated")
  `RIT_ASSERT_IMPL(a_col_bound, state_r == S_COL, idx_r <= IW'(col_lim), "colour index past limit")
  `RIT_ASSERT_IMPL(a_vis_bound, state_r == S_VIS, idx_r <= IW'(src_vc_r), "visual index past count")
endmodule
`default_nettype wire

@@ rtl/rit_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module rit_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ rtl/rit_remap.sv @@
// Exact remap unit: moves ID bits from source mask positions to target mask positions
`default_nettype none
module rit_remap (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rit_pkg::remap_req_t req,
  output rit_pkg::remap_rsp_t      rsp
);
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [rit_pkg::BIT_PW-1:0]   sb_r, sb_nxt, tb_r, tb_nxt;
  logic [rit_pkg::ID_W-1:0]     id_r, id_nxt, acc_r, acc_nxt;
  logic                         sbit, tbit, fin;

  assign sbit = req.src_mask[sb_r[rit_pkg::BIT_AW-1:0]];
  assign tbit = req.tgt_mask[tb_r[rit_pkg::BIT_AW-1:0]];
  assign fin  = sb_r[rit_pkg::BIT_AW] | tb_r[rit_pkg::BIT_AW];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    sb_nxt   = sb_r;
    tb_nxt   = tb_r;
    id_nxt   = id_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      sb_nxt   = '0;
      tb_nxt   = '0;
      id_nxt   = req.id;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (fin) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (!sbit) sb_nxt = sb_r + 1'b1;
        if (!tbit) tb_nxt = tb_r + 1'b1;
        if (sbit && tbit) begin
          acc_nxt[tb_r[rit_pkg::BIT_AW-1:0]] = id_r[sb_r[rit_pkg::BIT_AW-1:0]];
          sb_nxt = sb_r + 1'b1;
          tb_nxt = tb_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sb_r  <= sb_nxt;
    tb_r  <= tb_nxt;
    id_r  <= id_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r | req.tgt_base;
endmodule
`default_nettype wire

@@ tb/resource_id_translator_core_test.sv @@
// Testbench for the resource ID translator: predicted results checked item by item
`timescale 1ns / 100ps
`default_nettype none
module resource_id_translator_core_test;
  typedef struct packed {
    logic [2:0]               action;
    logic [2:0]               slot;
    logic [rit_pkg::ID_W-1:0] value;
  } xlate_item_t;

  typedef struct packed {
    logic [rit_pkg::ID_W-1:0] result_id;
    logic [2:0]               match_kind;
    logic                     table_full;
  } xlate_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rit_in_if  in_ch ();
  rit_out_if out_ch ();
  rit_cfg_if cfg_ch ();

  resource_id_translator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  logic [rit_pkg::ID_W-1:0] src_base, src_mask, tgt_base, tgt_mask;
  logic            exact_mode, color_on;
  logic [rit_pkg::ID_W-1:0] special_id [rit_pkg::SLOT_CNT];
  logic [rit_pkg::SLOT_CNT-1:0] special_set;
  logic [rit_pkg::ID_W-1:0] svis [rit_pkg::VIS_DEPTH];
  logic [rit_pkg::ID_W-1:0] tvis [rit_pkg::VIS_DEPTH];
  logic [rit_pkg::ID_W-1:0] scol [rit_pkg::COL_DEPTH];
  logic [rit_pkg::ID_W-1:0] tcol [rit_pkg::COL_DEPTH];
  int svis_n, tvis_n, scol_n, tcol_n;

  xlate_item_t   pending_items[$];
  xlate_result_t expected_results[$];
  int  errors = 0;
  int  n_results = 0;
  bit  quiet = 1'b0;
  bit  hold_in = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;

  function automatic logic [rit_pkg::ID_W-1:0] move_bits(logic [rit_pkg::ID_W-1:0] id);
    logic [rit_pkg::ID_W-1:0] res;
    int n, sc, tc, sb, tb;
    res = '0;
    sc = $countones(src_mask);
    tc = $countones(tgt_mask);
    n = (sc < tc) ? sc : tc;
    sb = 0;
    tb = 0;
    while (n > 0) begin
      while (sb < rit_pkg::ID_W && !src_mask[sb]) sb++;
      while (tb < rit_pkg::ID_W && !tgt_mask[tb]) tb++;
      if (sb >= rit_pkg::ID_W || tb >= rit_pkg::ID_W) break;
      if (id[sb]) res[tb] = 1'b1;
      sb++;
      tb++;
      n--;
    end
    return res | tgt_base;
  endfunction

  function automatic xlate_result_t translate_id(logic [rit_pkg::ID_W-1:0] id);
    xlate_result_t r;
    int lim;
    r.table_full = 1'b0;
    if ((id & ~src_mask) == src_base) begin
      r.result_id = exact_mode ? move_bits(id) : ((id & src_mask) | tgt_base);
      r.match_kind = rit_pkg::KIND_BASE;
      return r;
    end
    for (int i = 0; i < rit_pkg::SPEC_CNT; i++)
      if (special_set[i] && id == special_id[i]) begin
        r.result_id = special_id[i + rit_pkg::SPEC_CNT];
        r.match_kind = rit_pkg::KIND_ROOT + 3'(i);
        return r;
      end
    if (color_on) begin
      lim = (scol_n < tcol_n) ? scol_n : tcol_n;
      for (int i = 0; i < lim; i++)
        if (id == scol[i]) begin
          r.result_id = tcol[i];
          r.match_kind = rit_pkg::KIND_COLOR;
          return r;
        end
    end
    for (int i = 0; i < svis_n; i++)
      if (id == svis[i]) begin
        r.result_id = tvis[(i < tvis_n) ? i : 0];
        r.match_kind = rit_pkg::KIND_VIS;
        return r;
      end
    r.result_id = id;
    r.match_kind = rit_pkg::KIND_NONE;
    return r;
  endfunction

  function automatic xlate_result_t apply_item(xlate_item_t it);
    xlate_result_t r;
    r = '{result_id: '0, match_kind: rit_pkg::KIND_LOAD, table_full: 1'b0};
    case (it.action)
      rit_pkg::ACT_XLATE: r = translate_id(it.value);
      rit_pkg::ACT_CLEAR: begin
        special_set = '0;
        for (int i = 0; i < rit_pkg::SLOT_CNT; i++) special_id[i] = '0;
        for (int i = 0; i < rit_pkg::VIS_DEPTH; i++) begin
          svis[i] = '0;
          tvis[i] = '0;
        end
        for (int i = 0; i < rit_pkg::COL_DEPTH; i++) begin
          scol[i] = '0;
          tcol[i] = '0;
        end
        svis_n = 0;
        tvis_n = 0;
        scol_n = 0;
        tcol_n = 0;
      end
      rit_pkg::ACT_SPECIAL: if (it.slot < rit_pkg::SLOT_CNT) begin
        special_id[it.slot] = it.value;
        special_set[it.slot] = 1'b1;
      end
      rit_pkg::ACT_SVIS: if (svis_n >= rit_pkg::VIS_DEPTH) r.table_full = 1'b1;
        else svis[svis_n++] = it.value;
      rit_pkg::ACT_TVIS: if (tvis_n >= rit_pkg::VIS_DEPTH) r.table_full = 1'b1;
        else tvis[tvis_n++] = it.value;
      rit_pkg::ACT_SCOL: if (scol_n >= rit_pkg::COL_DEPTH) r.table_full = 1'b1;
        else scol[scol_n++] = it.value;
      rit_pkg::ACT_TCOL: if (tcol_n >= rit_pkg::COL_DEPTH) r.table_full = 1'b1;
        else tcol[tcol_n++] = it.value;
      default: ;
    endcase
    return r;
  endfunction

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.action <= '0;
      in_ch.slot <= '0;
      in_ch.value <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(apply_item(pending_items.pop_front()));
        if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 18);
      end
      if (in_ch.valid && !in_ch.ready) begin
        in_ch.valid <= 1'b1;
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0 && !hold_in) begin
        in_ch.valid <= 1'b1;
        in_ch.action <= pending_items[0].action;
        in_ch.slot <= pending_items[0].slot;
        in_ch.value <= pending_items[0].value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("result_id %h with no item outstanding", out_ch.result_id);
          errors++;
        end else begin
          xlate_result_t e;
          e = expected_results.pop_front();
          if (out_ch.result_id !== e.result_id) begin
            $error("result_id expected %h actual %h", e.result_id, out_ch.result_id);
            errors++;
          end
          if (out_ch.match_kind !== e.match_kind) begin
            $error("match_kind expected %0d actual %0d", e.match_kind, out_ch.match_kind);
            errors++;
          end
          if (out_ch.table_full !== e.table_full) begin
            $error("table_full expected %0d actual %0d", e.table_full, out_ch.table_full);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_gap = $urandom_range(1, 18) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push(logic [2:0] act, logic [2:0] slt, logic [rit_pkg::ID_W-1:0] val);
    pending_items.push_back('{action: act, slot: slt, value: val});
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_results.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [rit_pkg::ID_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      rit_pkg::REG_SRC_BASE: src_base = data;
      rit_pkg::REG_SRC_MASK: src_mask = data;
      rit_pkg::REG_TGT_BASE: tgt_base = data;
      rit_pkg::REG_TGT_MASK: tgt_mask = data;
      rit_pkg::REG_EXACT:    exact_mode = data[0];
      rit_pkg::REG_COLOR_EN: color_on = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(logic [rit_pkg::ID_W-1:0] sb, logic [rit_pkg::ID_W-1:0] sm,
                          logic [rit_pkg::ID_W-1:0] tb, logic [rit_pkg::ID_W-1:0] tm,
                          logic ex, logic ce);
    write_reg(rit_pkg::REG_SRC_BASE, sb);
    write_reg(rit_pkg::REG_SRC_MASK, sm);
    write_reg(rit_pkg::REG_TGT_BASE, tb);
    write_reg(rit_pkg::REG_TGT_MASK, tm);
    write_reg(rit_pkg::REG_EXACT, {31'(0), ex});
    write_reg(rit_pkg::REG_COLOR_EN, {31'(0), ce});
  endtask

  // Known IDs: recent table entries, so translates hit the lists often
  logic [rit_pkg::ID_W-1:0] known_ids[$];

  function automatic logic [rit_pkg::ID_W-1:0] rand_id();
    case ($urandom_range(0, 5))
      0, 1: return (known_ids.size() > 0) ?
                   known_ids[$urandom_range(0, known_ids.size() - 1)] : $urandom;
      2: return (src_base & ~src_mask) | ($urandom & src_mask);
      3: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // Well-formed table load followed by translates, with some noise mixed in
  task automatic random_phase(int n, int max_vis, int max_col);
    int nv, nc, k;
    logic [rit_pkg::ID_W-1:0] v;
    push(rit_pkg::ACT_CLEAR, 3'($urandom), $urandom);
    known_ids.delete();
    nv = $urandom_range(1, max_vis);
    nc = $urandom_range(0, max_col);
    for (int s = 0; s < rit_pkg::SLOT_CNT; s++)
      if ($urandom_range(0, 3) != 0) begin
        v = $urandom;
        push(rit_pkg::ACT_SPECIAL, 3'(s), v);
        if (s < rit_pkg::SPEC_CNT) known_ids.push_back(v);
      end
    for (int i = 0; i < nv; i++) begin
      v = $urandom;
      known_ids.push_back(v);
      push(rit_pkg::ACT_SVIS, 3'($urandom), v);
      push(rit_pkg::ACT_TVIS, 3'($urandom), $urandom);
    end
    for (int i = 0; i < nc; i++) begin
      v = $urandom;
      known_ids.push_back(v);
      push(rit_pkg::ACT_SCOL, 3'($urandom), v);
      push(rit_pkg::ACT_TCOL, 3'($urandom), $urandom);
    end
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      if (k < 15) push(rit_pkg::ACT_XLATE, 3'($urandom), rand_id());
      else if (k < 17) push(rit_pkg::ACT_SPECIAL, 3'($urandom), rand_id());
      else if (k < 18)
        push(3'($urandom_range(rit_pkg::ACT_SVIS, rit_pkg::ACT_TVIS)), 3'($urandom), $urandom);
      else push(3'($urandom_range(rit_pkg::ACT_SCOL, 7)), 3'($urandom), $urandom);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.slot = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    src_base = '0; src_mask = '0; tgt_base = '0; tgt_mask = '0;
    exact_mode = 1'b0; color_on = 1'b0;
    special_set = '0;
    for (int i = 0; i < rit_pkg::SLOT_CNT; i++) special_id[i] = '0;
    svis_n = 0; tvis_n = 0; scol_n = 0; tcol_n = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: base defaults to zero so make base a narrow window first
    set_regs(32'hFFFF_0000, 32'h0000_00FF, 32'h00A0_0000, 32'hFF00_0000, 1'b0, 1'b1);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'hFFFF_0012);
    push(rit_pkg::ACT_XLATE, 3'd7, 32'h0000_0000);
    push(rit_pkg::ACT_SPECIAL, 3'd0, 32'h1111_1111);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'h1111_1111);
    push(rit_pkg::ACT_SPECIAL, 3'd3, 32'hFFFF_FFFF);
    push(rit_pkg::ACT_SPECIAL, 3'd1, 32'h2222_2222);
    push(rit_pkg::ACT_SPECIAL, 3'd2, 32'h3333_3333);
    push(rit_pkg::ACT_SPECIAL, 3'd5, 32'h5555_5555);
    push(rit_pkg::ACT_SPECIAL, 3'd6, 32'h4444_4444);
    push(rit_pkg::ACT_SPECIAL, 3'd7, 32'h4444_4444);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'h1111_1111);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'h2222_2222);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'h3333_3333);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'h4444_4444);
    push(rit_pkg::ACT_SCOL, 3'd0, 32'hC0C0_0001);
    push(rit_pkg::ACT_SCOL, 3'd0, 32'hC0C0_0002);
    push(rit_pkg::ACT_TCOL, 3'd0, 32'hD0D0_0001);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'hC0C0_0001);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'hC0C0_0002);
    push(rit_pkg::ACT_SVIS, 3'd0, 32'hA0A0_0000);
    push(rit_pkg::ACT_SVIS, 3'd0, 32'hA0A0_0001);
    push(rit_pkg::ACT_TVIS, 3'd0, 32'hB0B0_0000);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'hA0A0_0001);
    push(3'd7, 3'd0, 32'hFFFF_FFFF);
    drain();

    // Exact remap, colour off, full lists
    set_regs(32'h0, 32'hF0F0_F0F0, 32'h8000_0000, 32'h0000_0FFF, 1'b1, 1'b0);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'hF0F0_F0F0);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'hC0C0_0001);
    push(rit_pkg::ACT_CLEAR, 3'd0, 32'h0);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'h1111_1111);
    for (int i = 0; i <= rit_pkg::VIS_DEPTH; i++)
      push(rit_pkg::ACT_SVIS, 3'd0, 32'h7700_0000 + i);
    push(rit_pkg::ACT_TVIS, 3'd0, 32'h6600_0000);
    for (int i = 0; i <= rit_pkg::COL_DEPTH; i++)
      push(rit_pkg::ACT_SCOL, 3'd0, 32'h5500_0000 + i);
    for (int i = 0; i < 4; i++) push(rit_pkg::ACT_TCOL, 3'd0, 32'h4400_0000 + i);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'h7700_001F);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'h5500_00FF);
    drain();
    write_reg(rit_pkg::REG_COLOR_EN, 32'h1);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'h5500_00FF);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'h5500_0002);
    push(rit_pkg::ACT_XLATE, 3'd0, 32'h7700_0000);
    drain();

    // Random phases over several register settings, extremes included
    set_regs(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1);
    random_phase(10, 4, 4);
    drain();
    set_regs(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1);
    random_phase(10, 4, 2);
    drain();
    for (int p = 0; p < 2; p++) begin
      set_regs($urandom, $urandom, $urandom, $urandom, 1'($urandom), 1'($urandom));
      write_reg(rit_pkg::REG_SRC_BASE, src_base & ~src_mask);
      random_phase(10, 4, 4);
      // hold off until every outstanding item has answered
      hold_in = 1'b1;
      while (expected_results.size() > 0 || in_ch.valid) @(posedge clk);
      hold_in = 1'b0;
      random_phase(4, 2, 2);
      drain();
    end
    quiet = 1'b1;
    set_regs($urandom & 32'hFFFF_0000, 32'h0000_FFFF, $urandom, $urandom, 1'b1, 1'b1);
    random_phase(10, 4, 4);
    drain();

    $display("Covered %0d results over base, special, colour, visual and miss paths,",
             n_results);
    $display("both remap modes, full lists, clear and ignored loads.");
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/rit_pkg.sv
rtl/rit_if.sv
rtl/rit_ram.sv
rtl/rit_remap.sv
rtl/resource_id_translator_core.sv
tb/resource_id_translator_core_test.sv
